### hdl/imsa_pkg.sv
// Shared types and constants for the indicator-matrix scatter-accumulate unit.
// Used by the channel interfaces, the register block, controller and datapath.
package imsa_pkg;

  localparam int unsigned MaxColumnsDef = 1024;

  localparam int unsigned ColW    = 11;  // signed column index
  localparam int unsigned ValW    = 32;  // Q16.16 weight and row value
  localparam int unsigned SumW    = 48;  // Q32.16 accumulator
  localparam int unsigned ProdW   = 2 * ValW;
  localparam int unsigned FracW   = 16;
  localparam int unsigned CountW  = 11;
  localparam int unsigned AddrW   = 4;   // APB byte address
  localparam int unsigned DataW   = 32;
  localparam int unsigned RegIdxW = 2;

  localparam logic [CountW-1:0] ColumnCountRst = CountW'(1024);

  // request types
  localparam logic ReqAccumulate = 1'b0;
  localparam logic ReqRead       = 1'b1;

  // result status
  localparam logic StatOk     = 1'b0;
  localparam logic StatReject = 1'b1;

  // register indexes (byte address / 4)
  localparam logic [RegIdxW-1:0] RegWeighted = 2'd0;
  localparam logic [RegIdxW-1:0] RegSkipNeg  = 2'd1;
  localparam logic [RegIdxW-1:0] RegColCount = 2'd2;

  typedef struct packed {
    logic              weighted;
    logic              skip_neg;
    logic [CountW-1:0] column_count;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic in_ready;
    logic accept;    // word taken this cycle
    logic clr_step;  // zero one store entry
    logic mem_rd;    // read store, register product
    logic commit;    // write back, load result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_valid;
    logic clr_last;
    logic need_result;
    logic out_blocked;
  } dp_status_t;

endpackage

### hdl/imsa_chan_if.sv
// Request and result channel interfaces (valid/ready plus payload).
// Depends on imsa_pkg for field widths.
interface imsa_in_if;
  import imsa_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   req_type;
  logic signed [ColW-1:0] column_index;
  logic signed [ValW-1:0] weight;
  logic signed [ValW-1:0] row_value;

  modport source (output valid, req_type, column_index, weight, row_value, input ready);
  modport sink (input valid, req_type, column_index, weight, row_value, output ready);
endinterface

interface imsa_out_if;
  import imsa_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [SumW-1:0] column_sum;
  logic signed [ColW-1:0] column_echo;
  logic                   status;

  modport source (output valid, column_sum, column_echo, status, input ready);
  modport sink (input valid, column_sum, column_echo, status, output ready);
endinterface

### hdl/imsa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module imsa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/imsa_cfg.sv
// APB configuration registers: weighted mode, skip-negative mode, column count.
// Depends on imsa_pkg.
module imsa_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [imsa_pkg::AddrW-1:0]  paddr,
  input  logic [imsa_pkg::DataW-1:0]  pwdata,
  output logic [imsa_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  output imsa_pkg::cfg_t              cfg_o
);
  import imsa_pkg::*;

  logic              weighted_q, weighted_d;
  logic              skip_neg_q, skip_neg_d;
  logic [CountW-1:0] col_count_q, col_count_d;
  logic              wr_en;
  logic [RegIdxW-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[AddrW-1:2];

  always_comb begin
    weighted_d  = weighted_q;
    skip_neg_d  = skip_neg_q;
    col_count_d = col_count_q;
    if (wr_en) begin
      case (reg_idx)
        RegWeighted: weighted_d  = pwdata[0];
        RegSkipNeg:  skip_neg_d  = pwdata[0];
        RegColCount: col_count_d = pwdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegWeighted: prdata = DataW'(weighted_q);
      RegSkipNeg:  prdata = DataW'(skip_neg_q);
      RegColCount: prdata = DataW'(col_count_q);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weighted_q  <= 1'b1;
      skip_neg_q  <= 1'b1;
      col_count_q <= ColumnCountRst;
    end else begin
      weighted_q  <= weighted_d;
      skip_neg_q  <= skip_neg_d;
      col_count_q <= col_count_d;
    end
  end

  assign cfg_o = '{weighted: weighted_q, skip_neg: skip_neg_q, column_count: col_count_q};

endmodule

### hdl/imsa_ctrl.sv
// Sequencer: store clearing after reset, then accept / read / update per word.
// Depends on imsa_pkg (cmd_t, dp_status_t).
module imsa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  imsa_pkg::dp_status_t st_i,
  output imsa_pkg::cmd_t       cmd_o
);
  import imsa_pkg::*;

  localparam logic [1:0] StClear  = 2'd0;
  localparam logic [1:0] StIdle   = 2'd1;
  localparam logic [1:0] StRead   = 2'd2;
  localparam logic [1:0] StUpdate = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StClear: begin
        cmd_o.clr_step = 1'b1;
        if (st_i.clr_last) state_d = StIdle;
      end
      StIdle: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.accept   = st_i.in_valid;
        if (st_i.in_valid) state_d = StRead;
      end
      StRead: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = StUpdate;
      end
      StUpdate: begin
        // hold while a result is due and the output slot cannot take it
        if (!(st_i.need_result && st_i.out_blocked)) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

  a_clear_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StClear && st_i.clr_last) |=> state_q == StIdle)
    else $error("clear pass did not hand over to idle");

  a_read_then_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRead |=> state_q == StUpdate)
    else $error("store read not followed by update");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.commit && st_i.need_result) |-> !st_i.out_blocked)
    else $error("result committed into a full output slot");

endmodule

### hdl/imsa_dp.sv
// Datapath: request register, multiplier, column store, saturating add, result register.
// Depends on imsa_pkg, imsa_chan_if and imsa_ram.
module imsa_dp #(
  parameter int unsigned MaxColumns = imsa_pkg::MaxColumnsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  imsa_pkg::cfg_t       cfg_i,
  input  imsa_pkg::cmd_t       cmd_i,
  output imsa_pkg::dp_status_t st_o,
  imsa_in_if.sink              in_ch,
  imsa_out_if.source           out_ch
);
  import imsa_pkg::*;

  localparam int unsigned AW      = $clog2(MaxColumns);
  localparam int unsigned LimBits = $clog2(MaxColumns + 1);
  localparam int unsigned LimW    = (LimBits > CountW) ? LimBits : CountW;
  localparam logic [LimW-1:0] MaxLim  = LimW'(MaxColumns);
  localparam logic [AW-1:0]   LastAdr = AW'(MaxColumns - 1);
  localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

  // request registers
  logic                   is_read_q;
  logic                   valid_q;
  logic                   skip_q;
  logic                   weighted_q;
  logic signed [ColW-1:0] col_q;
  logic [AW-1:0]          addr_q;
  logic signed [ValW-1:0] w_q, y_q;
  logic signed [ProdW-1:0] prod_q;

  logic [AW-1:0]          clr_cnt_q;
  logic                   out_valid_q;
  logic signed [SumW-1:0] out_sum_q;
  logic signed [ColW-1:0] out_echo_q;
  logic                   out_status_q;

  logic [LimW-1:0]        cnt_ext, limit, col_mag;
  logic                   in_neg, in_valid_col;
  logic signed [SumW-1:0] rd_sum, add_term, sat_sum, wr_data;
  logic signed [SumW:0]   wide_sum;
  logic                   need_result;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;

  // column check on the incoming word
  assign cnt_ext      = LimW'(cfg_i.column_count);
  assign limit        = (cnt_ext < MaxLim) ? cnt_ext : MaxLim;
  assign in_neg       = in_ch.column_index[ColW-1];
  assign col_mag      = LimW'(in_ch.column_index[ColW-2:0]);
  assign in_valid_col = !in_neg && (col_mag < limit);

  assign in_ch.ready = cmd_i.in_ready;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      is_read_q  <= (in_ch.req_type == ReqRead);
      valid_q    <= in_valid_col;
      skip_q     <= (in_ch.req_type == ReqAccumulate) && in_neg && cfg_i.skip_neg;
      weighted_q <= cfg_i.weighted;
      col_q      <= in_ch.column_index;
      addr_q     <= AW'(in_ch.column_index[ColW-2:0]);
      w_q        <= in_ch.weight;
      y_q        <= in_ch.row_value;
    end
    if (cmd_i.mem_rd) begin
      prod_q <= w_q * y_q;
    end
  end

  // floor to Q32.16 is the arithmetic shift, i.e. dropping the low bits
  assign add_term = weighted_q ? prod_q[ProdW-1:FracW]
                               : {{(SumW-ValW){y_q[ValW-1]}}, y_q};
  assign wide_sum = {rd_sum[SumW-1], rd_sum} + {add_term[SumW-1], add_term};
  always_comb begin
    if (wide_sum[SumW] != wide_sum[SumW-1]) begin
      sat_sum = wide_sum[SumW] ? SumMin : SumMax;
    end else begin
      sat_sum = wide_sum[SumW-1:0];
    end
  end

  assign need_result = is_read_q || !(valid_q || skip_q);
  assign wr_data     = is_read_q ? '0 : sat_sum;
  assign mem_we      = cmd_i.clr_step || (cmd_i.commit && valid_q);
  assign mem_waddr   = cmd_i.clr_step ? clr_cnt_q : addr_q;

  imsa_ram #(
    .Width (SumW),
    .Depth (MaxColumns)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (cmd_i.clr_step ? '0 : wr_data),
    .re_i    (cmd_i.mem_rd),
    .raddr_i (addr_q),
    .rdata_o (rd_sum)
  );

  // clear pointer and result slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_step) clr_cnt_q <= clr_cnt_q + AW'(1);
      if (cmd_i.commit && need_result) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && need_result) begin
      out_sum_q    <= (is_read_q && valid_q) ? rd_sum : '0;
      out_echo_q   <= col_q;
      out_status_q <= valid_q ? StatOk : StatReject;
    end
  end

  assign out_ch.valid       = out_valid_q;
  assign out_ch.column_sum  = out_sum_q;
  assign out_ch.column_echo = out_echo_q;
  assign out_ch.status      = out_status_q;

  assign st_o = '{in_valid:    in_ch.valid,
                  clr_last:    (clr_cnt_q == LastAdr),
                  need_result: need_result,
                  out_blocked: out_valid_q && !out_ch.ready};

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == StatReject) |-> out_sum_q == '0)
    else $error("rejected word carries a nonzero sum");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.commit && need_result))
    else $error("result appeared without a commit");

  a_write_valid_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && mem_we) |-> (valid_q && !skip_q))
    else $error("store written for a rejected or skipped word");

endmodule

### hdl/indicator_matrix_scatter_accumulate_unit.sv
// Top level of the indicator-matrix scatter-accumulate unit (weighted bincount).
// Depends on imsa_pkg, imsa_chan_if, imsa_cfg, imsa_ctrl, imsa_dp, imsa_ram.
//
// Usage: words arrive on in_ch (valid/ready). An accumulate word adds
// floor(weight*row_value) in Q16.16, or row_value alone when weighted mode is
// off, into its column's 48-bit saturating sum; it gives no result unless the
// column is rejected. A read word returns the column sum on out_ch and clears
// it. Rejected columns (negative, or beyond column_count) return sum 0 with
// status 1; negative accumulate columns are dropped in skip mode.
// Timing: a word passes accept, store read + multiply and write-back in turn,
// and the next word is taken only after write-back, owing to the single
// read-modify-write pass on the column store; its result is loaded at write-back.
// Reset: the config registers return to their reset values and the column
// store is zeroed by a clearing pass over all MaxColumns entries, during which
// in_ch.ready stays low; APB writes are taken throughout.
// Stall: the result register holds its word while out_ch.ready is low; a
// further word is still accepted and processed, and waits only if it
// produces a result while the slot is full.
module indicator_matrix_scatter_accumulate_unit #(
  parameter int unsigned MaxColumns = imsa_pkg::MaxColumnsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  imsa_in_if.sink                    in_ch,
  imsa_out_if.source                 out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [imsa_pkg::AddrW-1:0] paddr,
  input  logic [imsa_pkg::DataW-1:0] pwdata,
  output logic [imsa_pkg::DataW-1:0] prdata,
  output logic                       pready
);
  import imsa_pkg::*;

  cfg_t       cfg;
  cmd_t       cmd;
  dp_status_t st;

  imsa_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  imsa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .st_i   (st),
    .cmd_o  (cmd)
  );

  imsa_dp #(
    .MaxColumns (MaxColumns)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .cmd_i  (cmd),
    .st_o   (st),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule
